@@ rtl/atle_pkg.sv @@
// ----------------------------------------------------------------------------
// atle_pkg
// Types and constants shared by the address table with LRU eviction.
// ----------------------------------------------------------------------------
`default_nettype none

package atle_pkg;

    localparam int DEVICES      = 16;
    localparam int READING_BITS = 32;
    localparam int RESULT_LIMIT = 16;
    localparam int IDX_W        = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int SCAN_W       = IDX_W + 1;

    localparam logic [4:0]  DEV_CNT_MAX = 5'd31;
    localparam logic [15:0] EVICT_MAX   = 16'hFFFF;
    localparam logic [31:0] STALE_RESET = 32'd60;

    typedef enum logic [1:0] {
        FN_UPSERT   = 2'd0,
        FN_SNAPSHOT = 2'd1,
        FN_CLEAR    = 2'd2,
        FN_NONE     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPS_SCAN,
        ST_UPS_WRITE,
        ST_SNAP_SCAN,
        ST_FLUSH,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [1:0]         func;
        logic [47:0]        address;
        logic signed [7:0]  rssi;
        logic [31:0]        reading_word;
        logic [31:0]        now_seconds;
        logic [4:0]         emit_cap;
    } t_req;

    typedef struct packed {
        logic               entry_valid;
        logic [47:0]        out_address;
        logic signed [7:0]  out_rssi;
        logic [31:0]        out_reading;
        logic [31:0]        out_last_seen;
        logic               last_of_run;
        logic [4:0]         device_count;
        logic [15:0]        evicted_count;
    } t_res;

    typedef struct packed {
        logic [47:0]             address;
        logic signed [7:0]       rssi;
        logic [READING_BITS-1:0] reading;
        logic [31:0]             last_seen;
    } t_slot;

endpackage

`default_nettype wire

@@ rtl/address_table_lru_evict_top.sv @@
// ----------------------------------------------------------------------------
// address_table_lru_evict_top
// Device table keyed by 48-bit address: upsert with LRU eviction, age
// filtered snapshot read-out, and table clear.
//
//   channel   direction  handshake                 payload
//   request   in         start, busy               i_req  (t_req)
//   result    out        o_res_strobe              o_res  (t_res)
//   config    in         i_cfg_valid, o_cfg_ready  i_cfg_data (stale limit)
//
// Upsert and snapshot requests scan the slot memory one entry per cycle
// (one read port). Upsert: scan, then write, then a single result strobe.
// Snapshot: results strobed as entries qualify; the scan stops at the limit.
// Clear, unused codes and zero-limit snapshot skip the scan. busy stays high
// until the final result.
// Reset clears the in-use bits and counters and sets the stale limit to 60;
// memory is not cleared. Results cannot be stalled; config is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module address_table_lru_evict_top (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire atle_pkg::t_req   i_req,
    output logic                  o_res_strobe,
    output atle_pkg::t_res        o_res,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [31:0]      i_cfg_data
);

    import atle_pkg::*;

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    logic [SCAN_W-1:0]    r_rd_addr, n_rd_addr;
    logic                 r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]     r_rd_idx, n_rd_idx;
    t_slot                r_rd_data;
    logic                 r_hit_fnd, n_hit_fnd;
    logic [IDX_W-1:0]     r_hit_idx, n_hit_idx;
    logic                 r_free_fnd, n_free_fnd;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic [31:0]          r_min_ls, n_min_ls;
    logic [IDX_W-1:0]     r_min_idx, n_min_idx;
    logic                 r_pend_vld, n_pend_vld;
    t_slot                r_pend, n_pend;
    logic [4:0]           r_cnt, n_cnt;
    logic [4:0]           r_limit, n_limit;
    logic [DEVICES-1:0]   r_in_use, n_in_use;
    logic [15:0]          r_evict, n_evict;
    logic [4:0]           r_dev_cnt, n_dev_cnt;
    logic [31:0]          r_stale;
    logic                 r_res_strobe, n_res_strobe;
    t_res                 r_res, n_res;

    t_slot                r_mem [DEVICES];
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_idx;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    t_slot                wr_data;

    function automatic t_res entry_res(input t_slot s, input logic last,
                                       input logic [4:0] dc, input logic [15:0] ec);
        t_res r;
        r.entry_valid   = 1'b1;
        r.out_address   = s.address;
        r.out_rssi      = s.rssi;
        r.out_reading   = 32'(s.reading);
        r.out_last_seen = s.last_seen;
        r.last_of_run   = last;
        r.device_count  = dc;
        r.evicted_count = ec;
        return r;
    endfunction

    function automatic t_res empty_res(input logic [4:0] dc, input logic [15:0] ec);
        t_res r;
        r               = '0;
        r.last_of_run   = 1'b1;
        r.device_count  = dc;
        r.evicted_count = ec;
        return r;
    endfunction

    assign busy         = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_res_strobe = r_res_strobe;
    assign o_res        = r_res;

    // slot memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_idx] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rd_vld     <= 1'b0;
            r_in_use     <= '0;
            r_evict      <= '0;
            r_dev_cnt    <= '0;
            r_stale      <= STALE_RESET;
            r_res_strobe <= 1'b0;
            r_pend_vld   <= 1'b0;
            r_hit_fnd    <= 1'b0;
            r_free_fnd   <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rd_vld     <= n_rd_vld;
            r_in_use     <= n_in_use;
            r_evict      <= n_evict;
            r_dev_cnt    <= n_dev_cnt;
            r_res_strobe <= n_res_strobe;
            r_pend_vld   <= n_pend_vld;
            r_hit_fnd    <= n_hit_fnd;
            r_free_fnd   <= n_free_fnd;
            if (i_cfg_valid && o_cfg_ready) begin
                r_stale <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rd_addr  <= n_rd_addr;
        r_rd_idx   <= n_rd_idx;
        r_hit_idx  <= n_hit_idx;
        r_free_idx <= n_free_idx;
        r_min_ls   <= n_min_ls;
        r_min_idx  <= n_min_idx;
        r_pend     <= n_pend;
        r_cnt      <= n_cnt;
        r_limit    <= n_limit;
        r_res      <= n_res;
    end

    always_comb begin
        logic        last_idx;
        logic        qual;
        logic [31:0] age;

        n_state      = r_state;
        n_req        = r_req;
        n_rd_addr    = r_rd_addr;
        n_rd_vld     = 1'b0;
        n_rd_idx     = r_rd_addr[IDX_W-1:0];
        n_hit_fnd    = r_hit_fnd;
        n_hit_idx    = r_hit_idx;
        n_free_fnd   = r_free_fnd;
        n_free_idx   = r_free_idx;
        n_min_ls     = r_min_ls;
        n_min_idx    = r_min_idx;
        n_pend_vld   = r_pend_vld;
        n_pend       = r_pend;
        n_cnt        = r_cnt;
        n_limit      = r_limit;
        n_in_use     = r_in_use;
        n_evict      = r_evict;
        n_dev_cnt    = r_dev_cnt;
        n_res_strobe = 1'b0;
        n_res        = r_res;
        rd_en        = 1'b0;
        rd_idx       = r_rd_addr[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_idx       = r_hit_idx;
        wr_data.address   = r_req.address;
        wr_data.rssi      = r_req.rssi;
        wr_data.reading   = READING_BITS'(r_req.reading_word);
        wr_data.last_seen = r_req.now_seconds;

        last_idx = (r_rd_idx == IDX_W'(DEVICES - 1));
        age      = r_req.now_seconds - r_rd_data.last_seen;
        qual     = r_in_use[r_rd_idx] && (age <= r_stale);

        // read issue during scans
        if (r_state == ST_UPS_SCAN || r_state == ST_SNAP_SCAN) begin
            rd_en     = (r_rd_addr < SCAN_W'(DEVICES));
            n_rd_vld  = rd_en;
            if (rd_en) begin
                n_rd_addr = r_rd_addr + SCAN_W'(1);
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req      = i_req;
                    n_rd_addr  = '0;
                    n_hit_fnd  = 1'b0;
                    n_free_fnd = 1'b0;
                    n_pend_vld = 1'b0;
                    n_cnt      = '0;
                    n_limit    = (i_req.emit_cap > 5'(RESULT_LIMIT)) ?
                                 5'(RESULT_LIMIT) : i_req.emit_cap;
                    case (i_req.func)
                        FN_UPSERT: begin
                            n_state = ST_UPS_SCAN;
                        end
                        FN_SNAPSHOT: begin
                            n_state = (n_limit == '0) ? ST_RESP : ST_SNAP_SCAN;
                        end
                        FN_CLEAR: begin
                            n_in_use  = '0;
                            n_evict   = '0;
                            n_dev_cnt = '0;
                            n_state   = ST_RESP;
                        end
                        default: begin
                            n_state = ST_RESP;
                        end
                    endcase
                end
            end
            ST_UPS_SCAN: begin
                if (r_rd_vld) begin
                    if (!r_hit_fnd && r_in_use[r_rd_idx] &&
                        r_rd_data.address == r_req.address) begin
                        n_hit_fnd = 1'b1;
                        n_hit_idx = r_rd_idx;
                    end
                    if (!r_free_fnd && !r_in_use[r_rd_idx]) begin
                        n_free_fnd = 1'b1;
                        n_free_idx = r_rd_idx;
                    end
                    if (r_rd_idx == '0 || r_rd_data.last_seen < r_min_ls) begin
                        n_min_ls  = r_rd_data.last_seen;
                        n_min_idx = r_rd_idx;
                    end
                    if (last_idx) begin
                        n_state = ST_UPS_WRITE;
                    end
                end
            end
            ST_UPS_WRITE: begin
                wr_en = 1'b1;
                if (r_hit_fnd) begin
                    wr_idx = r_hit_idx;
                end else if (r_free_fnd) begin
                    wr_idx = r_free_idx;
                    if (r_dev_cnt != DEV_CNT_MAX) begin
                        n_dev_cnt = r_dev_cnt + 5'd1;
                    end
                end else begin
                    wr_idx = r_min_idx;
                    if (r_evict != EVICT_MAX) begin
                        n_evict = r_evict + 16'd1;
                    end
                end
                n_in_use[wr_idx] = 1'b1;
                n_state          = ST_RESP;
            end
            ST_SNAP_SCAN: begin
                if (r_rd_vld) begin
                    if (qual) begin
                        if (r_pend_vld) begin
                            n_res_strobe = 1'b1;
                            n_res        = entry_res(r_pend, 1'b0, r_dev_cnt, r_evict);
                        end
                        n_pend     = r_rd_data;
                        n_pend_vld = 1'b1;
                        n_cnt      = r_cnt + 5'd1;
                    end
                    if ((qual && (r_cnt + 5'd1) == r_limit) || last_idx) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                n_res_strobe = 1'b1;
                n_res        = r_pend_vld ? entry_res(r_pend, 1'b1, r_dev_cnt, r_evict)
                                          : empty_res(r_dev_cnt, r_evict);
                n_pend_vld   = 1'b0;
                n_state      = ST_IDLE;
            end
            ST_RESP: begin
                n_res_strobe = 1'b1;
                n_res        = empty_res(r_dev_cnt, r_evict);
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ sim/address_table_lru_evict_top_tb.sv @@
// ----------------------------------------------------------------------------
// address_table_lru_evict_top_tb
// Self-checking bench for the device table with LRU eviction. A directed
// sequence covers the field extremes, every function code, hits, misses,
// tie-broken evictions, age wrap and the stale boundary. Random requests
// follow under several stale limits. Each accepted request runs through
// a table model of its own that predicts the result stream, which the
// monitor checks field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module address_table_lru_evict_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import atle_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASE  = 72;
    localparam int POOL_SIZE     = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_req        i_req;
    logic        o_res_strobe;
    t_res        o_res;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data;

    address_table_lru_evict_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req        (i_req),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // table model
    logic [47:0]        tbl_addr    [DEVICES];
    logic signed [7:0]  tbl_rssi    [DEVICES];
    logic [31:0]        tbl_reading [DEVICES];
    logic [31:0]        tbl_seen    [DEVICES];
    logic [DEVICES-1:0] tbl_used;
    logic [15:0]        evict_total;
    logic [31:0]        age_limit;

    t_req        queued_requests [$];
    t_res        due_results [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          gap_left;
    bit          quiet;
    logic [31:0] clock_cursor;
    logic [47:0] addr_pool [POOL_SIZE];

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [4:0] live_devices();
        logic [4:0] n;
        n = '0;
        for (int i = 0; i < DEVICES; i++) begin
            if (tbl_used[i]) n++;
        end
        return n;
    endfunction

    task automatic apply_request(input t_req rq);
        int         hit;
        int         n;
        int         lim;
        int         picks [RESULT_LIMIT];
        logic [31:0] age;
        t_res       r;
        n = 0;
        case (t_func'(rq.func))
            FN_UPSERT: begin
                hit = -1;
                for (int i = 0; i < DEVICES; i++) begin
                    if (hit < 0 && tbl_used[i] && tbl_addr[i] == rq.address) hit = i;
                end
                if (hit < 0) begin
                    for (int i = 0; i < DEVICES; i++) begin
                        if (hit < 0 && !tbl_used[i]) hit = i;
                    end
                    if (hit < 0) begin
                        hit = 0;
                        for (int i = 1; i < DEVICES; i++) begin
                            if (tbl_seen[i] < tbl_seen[hit]) hit = i;
                        end
                        if (evict_total != EVICT_MAX) evict_total++;
                    end
                    tbl_addr[hit] = rq.address;
                    tbl_used[hit] = 1'b1;
                end
                tbl_rssi[hit]    = rq.rssi;
                tbl_reading[hit] = rq.reading_word;
                tbl_seen[hit]    = rq.now_seconds;
            end
            FN_CLEAR: begin
                tbl_used    = '0;
                evict_total = '0;
            end
            FN_SNAPSHOT: begin
                lim = (rq.emit_cap > RESULT_LIMIT) ? RESULT_LIMIT : int'(rq.emit_cap);
                for (int i = 0; i < DEVICES; i++) begin
                    age = rq.now_seconds - tbl_seen[i];
                    if (n < lim && tbl_used[i] && age <= age_limit) begin
                        picks[n] = i;
                        n++;
                    end
                end
            end
            default: ;
        endcase
        for (int k = 0; k < n; k++) begin
            r.entry_valid   = 1'b1;
            r.out_address   = tbl_addr[picks[k]];
            r.out_rssi      = tbl_rssi[picks[k]];
            r.out_reading   = tbl_reading[picks[k]];
            r.out_last_seen = tbl_seen[picks[k]];
            r.last_of_run   = (k == n - 1);
            r.device_count  = live_devices();
            r.evicted_count = evict_total;
            due_results.push_back(r);
        end
        if (n == 0) begin
            r               = '0;
            r.last_of_run   = 1'b1;
            r.device_count  = live_devices();
            r.evicted_count = evict_total;
            due_results.push_back(r);
        end
    endtask

    // driver
    always @(posedge i_clk) begin : drive_requests
        bit launch;
        if (!i_rst_n) begin
            start       <= 1'b0;
            gap_left    = 0;
            quiet       = 1'b0;
            tbl_used    = '0;
            evict_total = '0;
        end else begin
            launch = start;
            if (start && !busy) begin
                apply_request(i_req);
                launch   = 1'b0;
                gap_left = quiet ? 0 : $urandom_range(0, 12);
                if ($urandom_range(0, 29) == 0) quiet = !quiet;
            end else if (!launch && gap_left != 0 && !busy) begin
                gap_left--;
            end
            if (!launch && gap_left == 0 && queued_requests.size() != 0) begin
                i_req  <= queued_requests.pop_front();
                launch = 1'b1;
            end
            start <= launch;
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // monitor
    always @(posedge i_clk) begin : check_results
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %0h", $time, o_res);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                check_field("entry_valid",   64'(want.entry_valid),   64'(o_res.entry_valid));
                check_field("out_address",   64'(want.out_address),   64'(o_res.out_address));
                check_field("out_rssi",      {56'd0, want.out_rssi},  {56'd0, o_res.out_rssi});
                check_field("out_reading",   64'(want.out_reading),   64'(o_res.out_reading));
                check_field("out_last_seen", 64'(want.out_last_seen),
                            64'(o_res.out_last_seen));
                check_field("last_of_run",   64'(want.last_of_run),   64'(o_res.last_of_run));
                check_field("device_count",  64'(want.device_count),  64'(o_res.device_count));
                check_field("evicted_count", 64'(want.evicted_count),
                            64'(o_res.evicted_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_req make_req(input t_func f, input logic [47:0] a,
                                      input logic signed [7:0] s, input logic [31:0] w,
                                      input logic [31:0] t, input logic [4:0] m);
        t_req rq;
        rq.func         = f;
        rq.address      = a;
        rq.rssi         = s;
        rq.reading_word = w;
        rq.now_seconds  = t;
        rq.emit_cap     = m;
        return rq;
    endfunction

    function automatic t_req random_request();
        t_req        rq;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 49) == 0) begin
            clock_cursor += $urandom;
        end else if ($urandom_range(0, 3) != 0) begin
            clock_cursor += $urandom_range(1, 20);
        end
        rq.func         = (pick < 60) ? FN_UPSERT : (pick < 92) ? FN_SNAPSHOT :
                          (pick < 96) ? FN_CLEAR : FN_NONE;
        rq.address      = ($urandom_range(0, 19) == 0) ? {16'($urandom), 32'($urandom)} :
                          addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        rq.rssi         = 8'($urandom);
        rq.reading_word = $urandom;
        rq.now_seconds  = ($urandom_range(0, 29) == 0) ? 32'($urandom) : clock_cursor;
        rq.emit_cap     = 5'($urandom_range(0, 31));
        return rq;
    endfunction

    task automatic wait_idle();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || start || due_results.size() != 0 || busy);
    endtask

    task automatic write_stale_limit(input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        age_limit = value;
    endtask

    initial begin : run_test
        logic [31:0] stale_set [6];
        age_limit    = STALE_RESET;
        clock_cursor = 32'd1000;
        stale_set    = '{32'd0, 32'hFFFF_FFFF, 32'd5, 32'd1000, 32'($urandom), 32'd60};
        for (int i = 0; i < POOL_SIZE; i++) begin
            addr_pool[i] = {16'($urandom), 32'($urandom)};
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd0, 5'd16));
        queued_requests.push_back(make_req(FN_NONE, '1, -8'sd1, '1, '1, 5'd31));
        queued_requests.push_back(make_req(FN_UPSERT, '0, -8'sd128, '0, 32'd100, 5'd0));
        queued_requests.push_back(make_req(FN_UPSERT, '1, 8'sd127, '1, 32'd40, 5'd31));
        // equal age still qualifies
        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd100, 5'd31));
        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd101, 5'd16));
        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd100, 5'd0));
        queued_requests.push_back(make_req(FN_UPSERT, '0, 8'sd5, 32'h1234_5678, '1, 5'd0));
        // age wraps past zero
        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd5, 5'd16));
        for (int i = 1; i <= 14; i++) begin
            queued_requests.push_back(make_req(FN_UPSERT, 48'(i), 8'(i), 32'(i), 32'd200, 5'd0));
        end
        // full table: evict oldest, then lowest index on a tie
        queued_requests.push_back(make_req(FN_UPSERT, 48'h0A0A, 8'sd1, 32'd1, 32'd300, 5'd0));
        queued_requests.push_back(make_req(FN_UPSERT, 48'h0B0B, 8'sd2, 32'd2, 32'd300, 5'd0));
        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd300, 5'd17));
        queued_requests.push_back(make_req(FN_CLEAR, '0, 8'sd0, '0, 32'd0, 5'd0));
        queued_requests.push_back(make_req(FN_SNAPSHOT, '0, 8'sd0, '0, 32'd300, 5'd16));

        foreach (stale_set[p]) begin
            wait_idle();
            write_stale_limit(stale_set[p]);
            @(negedge i_clk);
            repeat (RANDOM_PHASE) queued_requests.push_back(random_request());
        end

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
